### src/window_peak_count_max_macros.svh
// Assertion macros for the sliding-window peak counter.
// Depends on nothing; included by the top level after its package import.
`ifndef WINDOW_PEAK_COUNT_MAX_MACROS_SVH
`define WINDOW_PEAK_COUNT_MAX_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WPCM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("window_peak_count_max: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WPCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("window_peak_count_max: check failed");

`endif

### src/wpcm_pkg.sv
// Shared constants for the sliding-window peak counter.
// No dependencies; imported by window_peak_count_max.
`timescale 1ns / 1ps

package wpcm_pkg;

    // Default sizing
    localparam int WINDOW_MAX_DEF  = 1024;
    localparam int MAX_LEN_DEF     = 65536;
    localparam int SAMPLE_BITS_DEF = 32;

    // Fixed field widths
    localparam int CFG_W   = 11;
    localparam int PARTS_W = 10;
    localparam int START_W = 17;

    // Window length register
    localparam logic [CFG_W-1:0] WLEN_RESET = CFG_W'(3);
    localparam int               WLEN_MIN   = 3;

endpackage

### src/window_peak_count_max.sv
// Sliding-window peak counter: top level, single module.
// A request marked last shows its result in the cycle after its acceptance.
// Throughput: one sample per cycle, limited only by the output register draining.
// The peak flag history is a one-bit-wide RAM of WINDOW_MAX entries, read ahead of use
// into a register; it needs no clearing pass because every entry is rewritten before read.
// Reset (rst_n, async, active low) empties the set, the output register and loads window_len = 3.
`timescale 1ns / 1ps

module window_peak_count_max #(
    parameter int WINDOW_MAX  = wpcm_pkg::WINDOW_MAX_DEF,
    parameter int MAX_LEN     = wpcm_pkg::MAX_LEN_DEF,
    parameter int SAMPLE_BITS = wpcm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // sample channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [SAMPLE_BITS-1:0]        sample,
    input  logic                          last,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [wpcm_pkg::PARTS_W-1:0]  parts,
    output logic [wpcm_pkg::START_W-1:0]  start_pos,
    // window length register write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wpcm_pkg::CFG_W-1:0]    window_len
);
    import wpcm_pkg::*;

`include "window_peak_count_max_macros.svh"

    // Widths derived from the sizing parameters
    localparam int KW = $clog2(WINDOW_MAX + 1);        // holds a clamped window length
    localparam int AW = $clog2(WINDOW_MAX);            // history RAM address
    localparam int IW = $clog2(MAX_LEN + 1);           // sample index, counts, start
    localparam int EW = ((IW > KW) ? IW : KW) + 1;     // index/length arithmetic
    localparam int LW = (KW > CFG_W) ? KW : CFG_W;     // clamp compare width

    // Clamp the register value into 3..WINDOW_MAX
    function automatic logic [KW-1:0] clamp_len(input logic [CFG_W-1:0] v);
        logic [LW-1:0] v_ext;
        v_ext = LW'(v);
        if (v_ext < LW'(WLEN_MIN))
            return KW'(WLEN_MIN);
        else if (v_ext > LW'(WINDOW_MAX))
            return KW'(WINDOW_MAX);
        else
            return KW'(v_ext);
    endfunction

    // Registers
    logic [CFG_W-1:0]       wlen_reg,  wlen_next;
    logic [IW-1:0]          idx_reg,   idx_next;
    logic [AW-1:0]          pos_reg,   pos_next;      // idx_reg modulo WINDOW_MAX
    logic [SAMPLE_BITS-1:0] r0_reg,    r0_next;       // previous sample
    logic [SAMPLE_BITS-1:0] r1_reg,    r1_next;       // sample before that
    logic [IW-1:0]          cnt_reg,   cnt_next;
    logic [IW-1:0]          best_reg,  best_next;
    logic [IW-1:0]          bstart_reg, bstart_next;
    logic                   out_valid_reg, out_valid_next;
    logic [PARTS_W-1:0]     parts_reg, parts_next;
    logic [START_W-1:0]     start_reg, start_next;
    logic                   hist_rd_reg;              // history flag at current window start

    // History RAM
    logic                   hist_mem [0:WINDOW_MAX-1];

    // Step logic
    logic                   in_acc, out_acc, cfg_acc;
    logic                   active;
    logic [KW-1:0]          k_cur, k_nxt;
    logic                   pk;
    logic [IW-1:0]          cnt_inc, cnt_dec;
    logic [EW-1:0]          idx_plus1, start_w;
    logic                   full_w, drop;
    logic [IW-1:0]          best_upd, bstart_upd;
    logic                   hist_we;
    logic [AW-1:0]          hist_wa, hist_ra;
    logic [KW:0]            ra_t;

    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid_reg && !out_stall;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign cfg_ready = 1'b1;
    // Hold input only while a finished result waits and the sink is stalling
    assign in_stall  = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign parts     = parts_reg;
    assign start_pos = start_reg;

    assign wlen_next = cfg_acc ? window_len : wlen_reg;
    assign k_cur     = clamp_len(wlen_reg);
    assign k_nxt     = clamp_len(wlen_next);

    // Samples past MAX_LEN in a set are dropped, but last still closes the set
    assign active = (EW'(idx_reg) < EW'(MAX_LEN));

    always_comb
    begin
        // Peak test on the middle of the last three samples
        pk      = (EW'(idx_reg) >= EW'(2)) && (r0_reg > r1_reg) && (r0_reg > sample);
        cnt_inc = cnt_reg + IW'(pk);

        // Window ending at this sample is complete once idx + 1 >= k
        idx_plus1 = EW'(idx_reg) + EW'(1);
        full_w    = (idx_plus1 >= EW'(k_cur));
        start_w   = idx_plus1 - EW'(k_cur);

        // Drop the peak at the window start as it leaves the interior
        drop    = full_w && (start_w != '0) && hist_rd_reg && (cnt_inc != '0);
        cnt_dec = cnt_inc - IW'(drop);

        best_upd   = best_reg;
        bstart_upd = bstart_reg;
        if (full_w && (cnt_dec > best_reg))
        begin
            best_upd   = cnt_dec;
            bstart_upd = IW'(start_w);
        end

        hist_wa = (pos_reg == '0) ? AW'(WINDOW_MAX - 1) : (pos_reg - AW'(1));
        hist_we = in_acc && active && (EW'(idx_reg) >= EW'(2));
    end

    always_comb
    begin
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        cnt_next       = cnt_reg;
        best_next      = best_reg;
        bstart_next    = bstart_reg;
        out_valid_next = out_valid_reg;
        parts_next     = parts_reg;
        start_next     = start_reg;

        if (out_acc)
            out_valid_next = 1'b0;

        if (in_acc)
        begin
            if (active)
            begin
                idx_next    = IW'(idx_plus1);
                pos_next    = (pos_reg == AW'(WINDOW_MAX - 1)) ? '0 : (pos_reg + AW'(1));
                r0_next     = sample;
                r1_next     = r0_reg;
                cnt_next    = cnt_dec;
                best_next   = best_upd;
                bstart_next = bstart_upd;
            end
            if (last)
            begin
                // Emit the best window and clear the set
                out_valid_next = 1'b1;
                parts_next     = PARTS_W'((IW + 1)'(active ? best_upd : best_reg) + (IW + 1)'(1));
                start_next     = START_W'((IW + 1)'(active ? bstart_upd : bstart_reg)
                                          + (IW + 1)'(1));
                idx_next       = '0;
                pos_next       = '0;
                r0_next        = '0;
                r1_next        = '0;
                cnt_next       = '0;
                best_next      = '0;
                bstart_next    = '0;
            end
        end
    end

    // Prefetch address: window start of the next request, modulo WINDOW_MAX
    always_comb
    begin
        ra_t = (KW + 1)'(pos_next) + (KW + 1)'(1);
        if (ra_t >= (KW + 1)'(k_nxt))
            hist_ra = AW'(ra_t - (KW + 1)'(k_nxt));
        else
            hist_ra = AW'(ra_t + (KW + 1)'(WINDOW_MAX) - (KW + 1)'(k_nxt));
    end

    // History RAM: one write, one registered read with write-through
    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_wa] <= pk;
        if (hist_we && (hist_wa == hist_ra))
            hist_rd_reg <= pk;
        else
            hist_rd_reg <= hist_mem[hist_ra];
    end

    // Control and set state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg      <= WLEN_RESET;
            idx_reg       <= '0;
            pos_reg       <= '0;
            r0_reg        <= '0;
            r1_reg        <= '0;
            cnt_reg       <= '0;
            best_reg      <= '0;
            bstart_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wlen_reg      <= wlen_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            r0_reg        <= r0_next;
            r1_reg        <= r1_next;
            cnt_reg       <= cnt_next;
            best_reg      <= best_next;
            bstart_reg    <= bstart_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        parts_reg <= parts_next;
        start_reg <= start_next;
    end

    // Checks
    `WPCM_ASSERT_NEXT(a_last_gives_result, clk, rst_n, in_acc && last, out_valid_reg)
    `WPCM_ASSERT_NEXT(a_index_advances, clk, rst_n, in_acc && !last && active,
                      idx_reg == IW'($past(idx_plus1)))
    `WPCM_ASSERT_NEXT(a_best_waits_full_window, clk, rst_n, in_acc && !last && !full_w,
                      best_reg == $past(best_reg))

endmodule
